@@ src/scale4x_pixel_art_upscaler_defines.svh @@
// Assertion macros shared by the scale4x upscaler RTL.
`ifndef SCALE4X_PIXEL_ART_UPSCALER_DEFINES_SVH
`define SCALE4X_PIXEL_ART_UPSCALER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define S4X_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("s4x: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define S4X_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("s4x: next-cycle check failed");

`endif

@@ src/s4x_pkg.sv @@
// Shared types and constants of the scale4x upscaler.
package s4x_pkg;

    localparam int PIX_W     = 32;
    localparam int RGB_W     = 24;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    // Control of one pass through the shared expansion unit.
    typedef struct packed {
        logic border;
        logic sub_x;
        logic sub_y;
    } t_exp_ctl;

endpackage

@@ src/s4x_frame_ram.sv @@
// Single-port frame store with a registered read.
module s4x_frame_ram import s4x_pkg::*; #(
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [PIX_W-1:0]         i_wdata,
    output logic [PIX_W-1:0]         o_rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/s4x_expand.sv @@
// Shared Scale2x sub-pixel compare and select unit.
module s4x_expand import s4x_pkg::*; (
    input  logic [PIX_W-1:0] i_e,
    input  logic [PIX_W-1:0] i_l,
    input  logic [PIX_W-1:0] i_r,
    input  logic [PIX_W-1:0] i_a,
    input  logic [PIX_W-1:0] i_b,
    input  t_exp_ctl         i_ctl,
    output logic [PIX_W-1:0] o_pix
);

    function automatic logic same_rgb(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] q);
        return p[RGB_W-1:0] == q[RGB_W-1:0];
    endfunction

    logic [PIX_W-1:0] vert;
    logic             flat;

    always_comb begin
        vert = i_ctl.sub_y ? i_b : i_a;
        // Borders and flat neighborhoods keep the center pixel.
        flat = i_ctl.border || same_rgb(i_a, i_b) || same_rgb(i_l, i_r);
        if (flat) begin
            o_pix = i_e;
        end else if (i_ctl.sub_x) begin
            o_pix = same_rgb(i_r, vert) ? i_r : i_e;
        end else begin
            o_pix = same_rgb(i_l, vert) ? i_l : i_e;
        end
    end

endmodule

@@ src/scale4x_pixel_art_upscaler.sv @@
// Scale4x upscaler top level: frame store, sequencer and shared expansion unit.
// Loads are taken one per cycle while no read is in progress. A read in range walks the fetch
// state, with 13 reads of the single-port frame store, then 5 pass-one and 1 pass-two steps of
// the shared unit, then the done state, which loads the output register; an out-of-range read
// goes straight to done. No new request is taken until the read has loaded the output register.
// Synchronous active-low reset clears control and sets width and height to 256, clamped to MAX_WIDTH and MAX_HEIGHT.
`include "scale4x_pixel_art_upscaler_defines.svh"

module scale4x_pixel_art_upscaler import s4x_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [7:0]           i_src_col,
    input  logic [7:0]           i_src_row,
    input  logic [9:0]           i_out_col,
    input  logic [9:0]           i_out_row,
    input  logic [PIX_W-1:0]     i_pixel_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_result_pixel,
    output logic                 o_out_of_range,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NFETCH = 13;
    localparam int NP1    = 5;
    localparam logic [3:0] FETCH_LAST = 4'(NFETCH);
    localparam logic [2:0] P1_LAST    = 3'(NP1 - 1);

    // Window slots around the source center.
    localparam int W_MID = 0;
    localparam int W_L1  = 1;
    localparam int W_R1  = 2;
    localparam int W_U1  = 3;
    localparam int W_D1  = 4;
    localparam int W_L2  = 5;
    localparam int W_R2  = 6;
    localparam int W_U2  = 7;
    localparam int W_D2  = 8;
    localparam int W_UL  = 9;
    localparam int W_UR  = 10;
    localparam int W_DL  = 11;
    localparam int W_DR  = 12;

    localparam logic [2:0] OFS_Z  = 3'b000;
    localparam logic [2:0] OFS_P1 = 3'b001;
    localparam logic [2:0] OFS_P2 = 3'b010;
    localparam logic [2:0] OFS_M1 = 3'b111;
    localparam logic [2:0] OFS_M2 = 3'b110;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_CALC1 = 5'b00100,
        ST_CALC2 = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        CEN_MID,
        CEN_LEFT,
        CEN_RIGHT,
        CEN_UP,
        CEN_DOWN
    } t_center;

    // Column and row offsets of each window slot, packed as {dx, dy}.
    function automatic logic [5:0] fetch_ofs(input logic [3:0] k);
        case (k)
            4'(W_MID): return {OFS_Z,  OFS_Z};
            4'(W_L1):  return {OFS_M1, OFS_Z};
            4'(W_R1):  return {OFS_P1, OFS_Z};
            4'(W_U1):  return {OFS_Z,  OFS_M1};
            4'(W_D1):  return {OFS_Z,  OFS_P1};
            4'(W_L2):  return {OFS_M2, OFS_Z};
            4'(W_R2):  return {OFS_P2, OFS_Z};
            4'(W_U2):  return {OFS_Z,  OFS_M2};
            4'(W_D2):  return {OFS_Z,  OFS_P2};
            4'(W_UL):  return {OFS_M1, OFS_M1};
            4'(W_UR):  return {OFS_P1, OFS_M1};
            4'(W_DL):  return {OFS_M1, OFS_P1};
            4'(W_DR):  return {OFS_P1, OFS_P1};
            default:   return {OFS_Z,  OFS_Z};
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d, input int max);
        if (d == '0) begin
            return DIM_W'(1);
        end else if (32'(d) > max) begin
            return DIM_W'(max);
        end
        return d;
    endfunction

    t_state            r_state, n_state;
    logic [DIM_W-1:0]  r_width, r_height;
    logic [9:0]        r_x, r_y;
    logic [3:0]        r_cnt, n_cnt;
    logic [2:0]        r_step, n_step;
    logic [PIX_W-1:0]  r_win [NFETCH];
    logic [PIX_W-1:0]  r_p1 [NP1];
    logic [PIX_W-1:0]  r_res;
    logic              r_res_oor;
    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic              r_out_oor;

    logic              in_accept;
    logic              read_oor;
    logic              out_load;
    logic              ld_ok;
    logic [AW-1:0]     ld_addr;
    logic [5:0]        f_ofs;
    logic [10:0]       f_col, f_row;
    logic              f_ok;
    logic [AW-1:0]     f_addr;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [PIX_W-1:0]  ram_rdata;

    t_center           cen;
    logic [9:0]        cc, rr;
    logic [8:0]        c2, r2;
    logic              sub_x1, sub_y1;
    logic [PIX_W-1:0]  x_e, x_l, x_r, x_a, x_b;
    t_exp_ctl          x_ctl;
    logic [PIX_W-1:0]  x_out;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign read_oor    = ({1'b0, i_out_col} >= {r_width, 2'b00}) ||
                         ({1'b0, i_out_row} >= {r_height, 2'b00});

    // Load address; loads beyond the store are dropped.
    assign ld_ok   = (32'(i_src_col) < MAX_WIDTH) && (32'(i_src_row) < MAX_HEIGHT);
    assign ld_addr = AW'(32'(i_src_row) * MAX_WIDTH + 32'(i_src_col));

    // Window fetch address; slots that fall off the store read entry zero and go unused.
    always_comb begin
        f_ofs  = fetch_ofs(r_cnt);
        f_col  = {3'b000, r_x[9:2]} + {{8{f_ofs[5]}}, f_ofs[5:3]};
        f_row  = {3'b000, r_y[9:2]} + {{8{f_ofs[2]}}, f_ofs[2:0]};
        f_ok   = !f_col[10] && !f_row[10] &&
                 (32'(f_col) < MAX_WIDTH) && (32'(f_row) < MAX_HEIGHT);
        f_addr = f_ok ? AW'(32'(f_row) * MAX_WIDTH + 32'(f_col)) : '0;
    end

    assign ram_we   = in_accept && (i_operation == OP_LOAD) && ld_ok;
    assign ram_addr = (r_state == ST_FETCH) ? f_addr : ld_addr;

    s4x_frame_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_pixel_value),
        .o_rdata(ram_rdata)
    );

    // Each pass-one step evaluates one 2x pixel of the plus around the 2x target.
    // The step and the target's parity pick which source pixel is its center.
    always_comb begin
        case (r_step)
            3'd0: begin
                cen    = CEN_MID;
                sub_x1 = r_x[1];
                sub_y1 = r_y[1];
            end
            3'd1: begin
                cen    = r_x[1] ? CEN_MID : CEN_LEFT;
                sub_x1 = ~r_x[1];
                sub_y1 = r_y[1];
            end
            3'd2: begin
                cen    = r_x[1] ? CEN_RIGHT : CEN_MID;
                sub_x1 = ~r_x[1];
                sub_y1 = r_y[1];
            end
            3'd3: begin
                cen    = r_y[1] ? CEN_MID : CEN_UP;
                sub_x1 = r_x[1];
                sub_y1 = ~r_y[1];
            end
            3'd4: begin
                cen    = r_y[1] ? CEN_DOWN : CEN_MID;
                sub_x1 = r_x[1];
                sub_y1 = ~r_y[1];
            end
            default: begin
                cen    = CEN_MID;
                sub_x1 = r_x[1];
                sub_y1 = r_y[1];
            end
        endcase
    end

    always_comb begin
        cc  = {2'b00, r_x[9:2]};
        rr  = {2'b00, r_y[9:2]};
        x_e = r_win[W_MID];
        x_l = r_win[W_L1];
        x_r = r_win[W_R1];
        x_a = r_win[W_U1];
        x_b = r_win[W_D1];
        case (cen)
            CEN_MID: begin
            end
            CEN_LEFT: begin
                cc  = {2'b00, r_x[9:2]} - 10'd1;
                x_e = r_win[W_L1];
                x_l = r_win[W_L2];
                x_r = r_win[W_MID];
                x_a = r_win[W_UL];
                x_b = r_win[W_DL];
            end
            CEN_RIGHT: begin
                cc  = {2'b00, r_x[9:2]} + 10'd1;
                x_e = r_win[W_R1];
                x_l = r_win[W_MID];
                x_r = r_win[W_R2];
                x_a = r_win[W_UR];
                x_b = r_win[W_DR];
            end
            CEN_UP: begin
                rr  = {2'b00, r_y[9:2]} - 10'd1;
                x_e = r_win[W_U1];
                x_l = r_win[W_UL];
                x_r = r_win[W_UR];
                x_a = r_win[W_U2];
                x_b = r_win[W_MID];
            end
            CEN_DOWN: begin
                rr  = {2'b00, r_y[9:2]} + 10'd1;
                x_e = r_win[W_D1];
                x_l = r_win[W_DL];
                x_r = r_win[W_DR];
                x_a = r_win[W_MID];
                x_b = r_win[W_D2];
            end
            default: begin
            end
        endcase
        x_ctl.border = (cc == '0) || (rr == '0) ||
                       ((cc + 10'd1) >= {1'b0, r_width}) ||
                       ((rr + 10'd1) >= {1'b0, r_height});
        x_ctl.sub_x  = sub_x1;
        x_ctl.sub_y  = sub_y1;

        // The second pass reuses the unit on the five pass-one results.
        c2 = r_x[9:1];
        r2 = r_y[9:1];
        if (r_state == ST_CALC2) begin
            x_e = r_p1[0];
            x_l = r_p1[1];
            x_r = r_p1[2];
            x_a = r_p1[3];
            x_b = r_p1[4];
            x_ctl.border = (c2 == '0) || (r2 == '0) ||
                           (({1'b0, c2} + 10'd1) >= {r_width, 1'b0}) ||
                           (({1'b0, r2} + 10'd1) >= {r_height, 1'b0});
            x_ctl.sub_x  = r_x[0];
            x_ctl.sub_y  = r_y[0];
        end
    end

    s4x_expand u_expand (
        .i_e  (x_e),
        .i_l  (x_l),
        .i_r  (x_r),
        .i_a  (x_a),
        .i_b  (x_b),
        .i_ctl(x_ctl),
        .o_pix(x_out)
    );

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_operation == OP_READ)) begin
                    n_cnt   = '0;
                    n_state = read_oor ? ST_DONE : ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == FETCH_LAST) begin
                    n_step  = '0;
                    n_state = ST_CALC1;
                end
            end
            ST_CALC1: begin
                n_step = r_step + 3'd1;
                if (r_step == P1_LAST) begin
                    n_state = ST_CALC2;
                end
            end
            ST_CALC2: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_width     <= clamp_dim(DIM_W'(256), MAX_WIDTH);
            r_height    <= clamp_dim(DIM_W'(256), MAX_HEIGHT);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_WIDTH) begin
                    r_width <= clamp_dim(i_cfg_data, MAX_WIDTH);
                end else if (i_cfg_index == REG_HEIGHT) begin
                    r_height <= clamp_dim(i_cfg_data, MAX_HEIGHT);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_operation == OP_READ)) begin
            r_x       <= i_out_col;
            r_y       <= i_out_row;
            r_res     <= '0;
            r_res_oor <= read_oor;
        end
        // Read data arrives in the cycle after its address.
        if ((r_state == ST_FETCH) && (r_cnt != '0)) begin
            r_win[r_cnt - 4'd1] <= ram_rdata;
        end
        if (r_state == ST_CALC1) begin
            r_p1[r_step] <= x_out;
        end
        if (r_state == ST_CALC2) begin
            r_res <= x_out;
        end
        if (out_load) begin
            r_out_pixel <= r_res;
            r_out_oor   <= r_res_oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_pixel = r_out_pixel;
    assign o_out_of_range = r_out_oor;

    `S4X_ASSERT_NEXT(a_load_stays_idle, i_clk, i_rst_n, in_accept && (i_operation == OP_LOAD), r_state == ST_IDLE)
    `S4X_ASSERT_NOW(a_fetch_count, i_clk, i_rst_n, r_state == ST_FETCH, r_cnt <= FETCH_LAST)
    `S4X_ASSERT_NOW(a_oor_zero, i_clk, i_rst_n, o_out_valid && o_out_of_range, o_result_pixel == '0)

endmodule
